FILE: rtl/ftms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float tolerance match scan package
// Shared widths, register indexes and stage types.
// ----------------------------------------------------------------------------
package ftms_pkg;

   localparam int WORD_W     = 32;
   localparam int OUT_ADDR_W = 48;
   localparam int OUT_CNT_W  = 16;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int SUM_W      = 28;

   localparam logic [15:0] CAPACITY_RST = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TARGET     = 3'd0,
      CSR_TOLERANCE  = 3'd1,
      CSR_CAPACITY   = 3'd2,
      CSR_INIT_COUNT = 3'd3,
      CSR_BASE       = 3'd4
   } csr_index_type;

   // magnitude add/subtract after alignment
   typedef struct packed {
      logic             invalid;   // NaN operand or inf - inf
      logic             inf;       // infinite operand
      logic [7:0]       exp;       // exponent of the larger operand
      logic [SUM_W-1:0] sum;       // aligned sum with guard, round, sticky
      logic             last_word;
   } align_type;

   typedef struct packed {
      logic in_tol;
      logic last_word;
   } cmp_type;

endpackage

FILE: rtl/ftms_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Word channel
// Valid/ready channel that carries one region word per beat.
// ----------------------------------------------------------------------------
interface ftms_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word_bits;
   logic        last_word;

   modport source (output valid, output word_bits, output last_word, input ready);
   modport sink   (input valid, input word_bits, input last_word, output ready);
endinterface

FILE: rtl/ftms_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one scan result per beat.
// ----------------------------------------------------------------------------
interface ftms_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [47:0] match_address;
   logic [15:0] match_count;
   logic        full_res;

   modport source (output valid, output hit, output match_address, output match_count,
                   output full_res, input ready);
   modport sink   (input valid, input hit, input match_address, input match_count,
                   input full_res, output ready);
endinterface

FILE: rtl/float_tolerance_match_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float tolerance match scan
// Tests region words as IEEE singles against a target within a tolerance.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one region word per beat with last_word on the final one.
//   rsp_if returns one beat per word: hit, byte address, match count and
//   the full flag. csr_we/csr_index/csr_wdata write target, tolerance,
//   capacity, initial count and base address; write only while idle.
//   A word beat passes through input alignment, normalise and round, then
//   the scan state and result register on its way to the result beat. One
//   word is taken every cycle while the receiver does not stall; the counter
//   update in the scan stage sets that rate.
//   Reset clears all stage valids, zeroes the offset and counter and loads
//   the register reset values (capacity all ones).
//   When the receiver stalls the result register holds its beat; each stage
//   still fills while empty, so up to three words are buffered before
//   req_if.ready drops.
// ----------------------------------------------------------------------------
module float_tolerance_match_scan #(
   parameter int ADDR_BITS  = 48,
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   ftms_req_if.sink                          req_if,
   ftms_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [ftms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ftms_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ftms_pkg::*;

   logic [31:0] target_ff, tolerance_ff;
   logic [15:0] capacity_ff, init_ff;
   logic [47:0] base_ff;
   logic        al_valid, al_ready, cmp_valid, cmp_ready;
   logic        count_load_in, count_load_ff;
   align_type   al_data;
   cmp_type     cmp_data;

   assign count_load_in = csr_we && csr_index == CSR_INIT_COUNT;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= '0;
         tolerance_ff <= '0;
         capacity_ff  <= CAPACITY_RST;
         init_ff      <= '0;
         base_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET:     target_ff    <= csr_wdata[31:0];
            CSR_TOLERANCE:  tolerance_ff <= csr_wdata[31:0];
            CSR_CAPACITY:   capacity_ff  <= csr_wdata[15:0];
            CSR_INIT_COUNT: init_ff      <= csr_wdata[15:0];
            CSR_BASE:       base_ff      <= csr_wdata[47:0];
            default: ;
         endcase
      end
   end

   // delay the counter load until the new initial count is held
   always_ff @(posedge clock) begin
      if (reset) begin
         count_load_ff <= 1'b0;
      end else begin
         count_load_ff <= count_load_in;
      end
   end

   ftms_align u_align (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .word_bits   (req_if.word_bits),
      .last_word   (req_if.last_word),
      .target_bits (target_ff),
      .out_valid   (al_valid),
      .out_ready   (al_ready),
      .out_data    (al_data)
   );

   ftms_norm u_norm (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (al_valid),
      .in_ready       (al_ready),
      .in_data        (al_data),
      .tolerance_bits (tolerance_ff),
      .out_valid      (cmp_valid),
      .out_ready      (cmp_ready),
      .out_data       (cmp_data)
   );

   ftms_scan #(
      .ADDR_BITS  (ADDR_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (cmp_valid),
      .in_ready      (cmp_ready),
      .in_data       (cmp_data),
      .capacity      (capacity_ff),
      .initial_count (init_ff),
      .base_address  (base_ff),
      .count_load    (count_load_ff),
      .rsp_if        (rsp_if)
   );
endmodule

FILE: rtl/ftms_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float align stage
// Orders the operands by magnitude, aligns the smaller and adds or subtracts.
// ----------------------------------------------------------------------------
module ftms_align (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         word_bits,
   input  logic                last_word,
   input  logic [31:0]         target_bits,
   output logic                out_valid,
   input  logic                out_ready,
   output ftms_pkg::align_type out_data
);
   import ftms_pkg::*;

   logic            valid_ff, valid_in;
   align_type       data_ff, data_in;
   logic            eff_sub, nan_w, nan_t, inf_w, inf_t, swap;
   logic [30:0]     mag_a, mag_b;
   logic [7:0]      exp_a, exp_b, diff;
   logic [5:0]      shamt;
   logic [26:0]     ext_a, ext_b, b_al;
   logic [53:0]     b_sh;

   always_comb begin
      eff_sub = word_bits[31] == target_bits[31];
      nan_w   = (&word_bits[30:23]) && (|word_bits[22:0]);
      nan_t   = (&target_bits[30:23]) && (|target_bits[22:0]);
      inf_w   = (&word_bits[30:23]) && !(|word_bits[22:0]);
      inf_t   = (&target_bits[30:23]) && !(|target_bits[22:0]);
      swap    = word_bits[30:0] < target_bits[30:0];
      mag_a   = swap ? target_bits[30:0] : word_bits[30:0];
      mag_b   = swap ? word_bits[30:0] : target_bits[30:0];
      // subnormals carry exponent one and no hidden bit
      exp_a   = (mag_a[30:23] == 8'd0) ? 8'd1 : mag_a[30:23];
      exp_b   = (mag_b[30:23] == 8'd0) ? 8'd1 : mag_b[30:23];
      ext_a   = {(mag_a[30:23] != 8'd0), mag_a[22:0], 3'b000};
      ext_b   = {(mag_b[30:23] != 8'd0), mag_b[22:0], 3'b000};
      diff    = exp_a - exp_b;
      shamt   = (diff > 8'd28) ? 6'd28 : diff[5:0];
      b_sh    = {ext_b, 27'd0} >> shamt;
      b_al    = {b_sh[53:28], b_sh[27] | (|b_sh[26:0])};

      data_in.invalid   = nan_w || nan_t || (inf_w && inf_t && eff_sub);
      data_in.inf       = inf_w || inf_t;
      data_in.exp       = exp_a;
      data_in.sum       = eff_sub ? ({1'b0, ext_a} - {1'b0, b_al})
                                  : ({1'b0, ext_a} + {1'b0, b_al});
      data_in.last_word = last_word;
   end

   // advance when the slot is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: rtl/ftms_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float normalise and compare stage
// Normalises and rounds the difference to nearest even, then tests it
// against the tolerance.
// ----------------------------------------------------------------------------
module ftms_norm (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ftms_pkg::align_type in_data,
   input  logic [31:0]         tolerance_bits,
   output logic                out_valid,
   input  logic                out_ready,
   output ftms_pkg::cmp_type   out_data
);
   import ftms_pkg::*;

   function automatic logic [4:0] lead_zeros(input logic [26:0] v);
      logic [4:0] n;
      logic       seen;
      n    = 5'd27;
      seen = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!seen && v[i]) begin
            n    = 5'(26 - i);
            seen = 1'b1;
         end
      end
      return n;
   endfunction

   logic        valid_ff, valid_in;
   cmp_type     data_ff, data_in;
   logic [26:0] norm_m;
   logic [8:0]  norm_e;
   logic [4:0]  lz, sh;
   logic [7:0]  e_room;
   logic        up, tol_nan;
   logic [31:0] rnd;
   logic [30:0] mag;

   always_comb begin
      lz     = lead_zeros(in_data.sum[26:0]);
      e_room = in_data.exp - 8'd1;
      sh     = (e_room < {3'b000, lz}) ? e_room[4:0] : lz;
      // carry out of the add: shift right, keep sticky
      if (in_data.sum[27]) begin
         norm_m = {in_data.sum[27:2], in_data.sum[1] | in_data.sum[0]};
         norm_e = {1'b0, in_data.exp} + 9'd1;
      end else begin
         norm_m = in_data.sum[26:0] << sh;
         norm_e = norm_m[26] ? ({1'b0, in_data.exp} - {4'd0, sh}) : 9'd0;
      end
      // round to nearest even; the carry runs into the exponent
      up  = norm_m[2] && (norm_m[1] || norm_m[0] || norm_m[3]);
      rnd = {norm_e, norm_m[25:3]} + {31'd0, up};
      mag = (in_data.inf || rnd[31:23] >= 9'd255) ? 31'h7F80_0000 : rnd[30:0];

      tol_nan = (&tolerance_bits[30:23]) && (|tolerance_bits[22:0]);
      data_in.in_tol    = !in_data.invalid && !tol_nan &&
                          (tolerance_bits[31] ? (mag == 31'd0 && tolerance_bits[30:0] == 31'd0)
                                              : (mag <= tolerance_bits[30:0]));
      data_in.last_word = in_data.last_word;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

FILE: rtl/ftms_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan state and result register
// Holds word offset, match counter and stop flag; forms each result beat.
// ----------------------------------------------------------------------------
module ftms_scan #(
   parameter int ADDR_BITS  = 48,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ftms_pkg::cmp_type in_data,
   input  logic [15:0]       capacity,
   input  logic [15:0]       initial_count,
   input  logic [47:0]       base_address,
   input  logic              count_load,
   ftms_rsp_if.source        rsp_if
);
   import ftms_pkg::*;

   localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   logic [ADDR_BITS-1:0]  offset_ff, offset_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_next;
   logic                  stop_ff, stop_in, stop_now, stop_next, hit, take;
   logic                  valid_ff, valid_in;
   logic                  hit_ff;
   logic [47:0]           addr_ff;
   logic [15:0]           rcount_ff;
   logic                  full_ff;
   logic [ADDR_BITS-1:0]  addr;
   logic [COUNT_BITS-1:0] init_cnt;

   assign in_ready = !valid_ff || rsp_if.ready;
   assign take     = in_ready && in_valid;
   assign init_cnt = COUNT_BITS'(initial_count);

   // decide hit and the stop flag for this word
   always_comb begin
      stop_now   = stop_ff || (CMP_W'(count_ff) >= CMP_W'(capacity));
      hit        = !stop_now && in_data.in_tol;
      count_next = hit ? count_ff + 1'b1 : count_ff;
      stop_next  = stop_now || (hit && (CMP_W'(count_next) >= CMP_W'(capacity)));
      addr       = ADDR_BITS'(base_address) + (offset_ff << 2);
   end

   // advance or reload the region state
   always_comb begin
      offset_in = offset_ff;
      count_in  = count_ff;
      stop_in   = stop_ff;
      if (take) begin
         if (in_data.last_word) begin
            offset_in = '0;
            count_in  = init_cnt;
            stop_in   = 1'b0;
         end else begin
            offset_in = offset_ff + 1'b1;
            count_in  = count_next;
            stop_in   = stop_next;
         end
      end else if (count_load && offset_ff == '0) begin
         count_in = init_cnt;
         stop_in  = 1'b0;
      end
   end

   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         count_ff  <= '0;
         stop_ff   <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         offset_ff <= offset_in;
         count_ff  <= count_in;
         stop_ff   <= stop_in;
         valid_ff  <= valid_in;
      end
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (take) begin
         hit_ff    <= hit;
         addr_ff   <= OUT_ADDR_W'(addr);
         rcount_ff <= OUT_CNT_W'(count_next);
         full_ff   <= stop_next;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.hit           = hit_ff;
   assign rsp_if.match_address = addr_ff;
   assign rsp_if.match_count   = rcount_ff;
   assign rsp_if.full_res      = full_ff;
endmodule

FILE: rtl/ftms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Float tolerance match scan checker
// Port-level properties of the result channel.
// ----------------------------------------------------------------------------
module ftms_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [47:0] rsp_address,
   input logic [15:0] rsp_count,
   input logic        rsp_full
);
   // no result beat straight after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("result beat right after reset");

   // a stalled beat stays
   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result beat dropped");

   // a stalled beat keeps its payload
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_address) && $stable(rsp_count) &&
                                  $stable(rsp_hit) && $stable(rsp_full))
      else $error("result payload changed under stall");

   // a recorded match always leaves a nonzero count
   a_hit_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_count != 16'd0) else $error("hit with zero count");
endmodule

bind float_tolerance_match_scan ftms_checker u_ftms_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_hit     (rsp_if.hit),
   .rsp_address (rsp_if.match_address),
   .rsp_count   (rsp_if.match_count),
   .rsp_full    (rsp_if.full_res)
);
